### src/dtcf_pkg.sv
// shared types and constants for the character frame store with depth test
// no dependencies; used by every module of the block

package dtcf_pkg;

    localparam int WIDTH_BITS      = 8;
    localparam int HEIGHT_BITS     = 7;
    localparam int CELL_INDEX_BITS = 13;
    localparam int INDEX1_BITS     = CELL_INDEX_BITS + 1;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_BITS  = 1;
    localparam int QUEUE_CNT_BITS  = 2;
    localparam int REM_CNT_BITS    = 4;

    localparam logic [WIDTH_BITS-1:0]     RESET_WIDTH  = 8'd80;
    localparam logic [HEIGHT_BITS-1:0]    RESET_HEIGHT = 7'd40;
    localparam logic [7:0]                SPACE_GLYPH  = 8'h20;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT   = 1'b1;

    typedef enum logic [1:0] {
        OP_PLOT      = 2'd0,
        OP_CLR_GLYPH = 2'd1,
        OP_CLR_DEPTH = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    // classification of one command as it travels front to back
    typedef struct packed {
        op_t  op;
        logic in_range;
    } ctl_t;

    // status of the remainder unit
    typedef struct packed {
        logic done;
        logic rem_zero;
    } rem_stat_t;

endpackage

### src/dtcf_front.sv
// front end: geometry registers, coordinate transform, bounds check, cell address
// depends on dtcf_pkg

module dtcf_front #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64,
    parameter int ADDR_BITS   = 13,
    parameter int DEPTH_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dtcf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dtcf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [1:0]                           cmd,
    input  logic signed [8:0]                    pos_x,
    input  logic signed [8:0]                    pos_y,
    input  logic [15:0]                          depth,
    input  logic [15:0]                          tie_depth,
    input  logic [7:0]                           glyph,
    input  logic [7:0]                           colour_index,
    input  logic [dtcf_pkg::CELL_INDEX_BITS-1:0] cell_index,
    output dtcf_pkg::ctl_t                       ctl,
    output logic [ADDR_BITS-1:0]                 addr,
    output logic [DEPTH_BITS-1:0]                depth_val,
    output logic [DEPTH_BITS-1:0]                tie_val,
    output logic [15:0]                          cell_data,
    output logic [dtcf_pkg::INDEX1_BITS-1:0]     index1,
    output logic [dtcf_pkg::WIDTH_BITS-1:0]      eff_w
);

    logic [dtcf_pkg::WIDTH_BITS-1:0]  width_reg;
    logic [dtcf_pkg::HEIGHT_BITS-1:0] height_reg;
    logic [dtcf_pkg::HEIGHT_BITS-1:0] eff_h;
    logic [10:0]                      col;
    logic [10:0]                      row;
    logic                             plot_in;
    logic                             read_in;
    logic [14:0]                      row_base;
    logic [15:0]                      plot_addr;
    logic [14:0]                      area;
    dtcf_pkg::op_t                    op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dtcf_pkg::RESET_WIDTH;
            height_reg <= dtcf_pkg::RESET_HEIGHT;
        end
        else if (cfg_we)
        begin
            if (cfg_index == dtcf_pkg::REG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_index == dtcf_pkg::REG_HEIGHT)
            begin
                height_reg <= cfg_data[dtcf_pkg::HEIGHT_BITS-1:0];
            end
        end
    end

    // oversized geometry saturates to the store size
    assign eff_w = (width_reg > MAX_COLUMNS) ? dtcf_pkg::WIDTH_BITS'(MAX_COLUMNS) : width_reg;
    assign eff_h = (height_reg > MAX_ROWS) ? dtcf_pkg::HEIGHT_BITS'(MAX_ROWS) : height_reg;

    // y flips, origin moves to the screen center
    assign col = {{2{pos_x[8]}}, pos_x} + {4'b0, eff_w[7:1]};
    assign row = {5'b0, eff_h[6:1]} - {{2{pos_y[8]}}, pos_y};

    assign plot_in = !col[10] && (col[9:0] < {2'b0, eff_w})
                  && !row[10] && (row[9:0] < {3'b0, eff_h});

    assign row_base  = {8'b0, row[6:0]} * {7'b0, eff_w};
    assign plot_addr = {1'b0, row_base} + {8'b0, col[7:0]};

    assign area    = {8'b0, eff_h} * {7'b0, eff_w};
    assign read_in = {2'b0, cell_index} < area;

    assign op = dtcf_pkg::op_t'(cmd);

    always_comb
    begin
        ctl.op = op;
        unique case (op)
            dtcf_pkg::OP_PLOT:
            begin
                ctl.in_range = plot_in;
                addr         = ADDR_BITS'(plot_addr);
            end
            dtcf_pkg::OP_READ:
            begin
                ctl.in_range = read_in;
                addr         = ADDR_BITS'(cell_index);
            end
            default:
            begin
                ctl.in_range = 1'b0;
                addr         = ADDR_BITS'(plot_addr);
            end
        endcase
    end

    assign depth_val = DEPTH_BITS'(depth);
    assign tie_val   = DEPTH_BITS'(tie_depth);
    assign cell_data = {colour_index, glyph};
    assign index1    = {1'b0, cell_index} + dtcf_pkg::INDEX1_BITS'(1);

endmodule

### src/dtcf_queue.sv
// short command queue between front end and back end
// depends on dtcf_pkg for depth and pointer widths

module dtcf_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head,
    output logic         empty,
    output logic         full
);

    logic [W-1:0]                          slot_reg [dtcf_pkg::QUEUE_DEPTH];
    logic [dtcf_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_reg;
    logic [dtcf_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_reg;
    logic [dtcf_pkg::QUEUE_CNT_BITS-1:0]   count_reg;
    logic [dtcf_pkg::QUEUE_CNT_BITS-1:0]   count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == dtcf_pkg::QUEUE_CNT_BITS'(dtcf_pkg::QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/dtcf_rem.sv
// bit-serial remainder unit: one restoring step per cycle, flags a zero remainder
// depends on dtcf_pkg

module dtcf_rem (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [dtcf_pkg::INDEX1_BITS-1:0]    dividend,
    input  logic [dtcf_pkg::WIDTH_BITS-1:0]     divisor,
    output dtcf_pkg::rem_stat_t                 stat
);

    logic                                   busy_reg;
    logic                                   done_reg;
    logic [dtcf_pkg::REM_CNT_BITS-1:0]      cnt_reg;
    logic [dtcf_pkg::WIDTH_BITS-1:0]        rem_reg;
    logic [dtcf_pkg::WIDTH_BITS-1:0]        rem_next;
    logic [dtcf_pkg::INDEX1_BITS-1:0]       shift_reg;
    logic [dtcf_pkg::WIDTH_BITS:0]          trial;

    assign trial = {rem_reg, shift_reg[dtcf_pkg::INDEX1_BITS-1]};

    always_comb
    begin
        if (trial >= {1'b0, divisor})
        begin
            rem_next = dtcf_pkg::WIDTH_BITS'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_next = dtcf_pkg::WIDTH_BITS'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == dtcf_pkg::REM_CNT_BITS'(dtcf_pkg::INDEX1_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            shift_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[dtcf_pkg::INDEX1_BITS-2:0], 1'b0};
        end
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

### src/dtcf_back.sv
// back end: glyph and depth stores, depth test, cell read, clear sweeps, results
// depends on dtcf_pkg and dtcf_rem

module dtcf_back #(
    parameter int CELLS      = 8192,
    parameter int ADDR_BITS  = 13,
    parameter int DEPTH_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  dtcf_pkg::ctl_t                    q_ctl,
    input  logic [ADDR_BITS-1:0]              q_addr,
    input  logic [DEPTH_BITS-1:0]             q_depth,
    input  logic [DEPTH_BITS-1:0]             q_tie,
    input  logic [15:0]                       q_data,
    input  logic [dtcf_pkg::INDEX1_BITS-1:0]  q_index1,
    input  logic [dtcf_pkg::WIDTH_BITS-1:0]   eff_w,
    output logic                              pop,
    output logic                              init_busy,
    output logic                              done,
    output logic                              written,
    output logic                              in_range,
    output logic [7:0]                        cell_glyph,
    output logic [7:0]                        cell_colour,
    output logic                              row_end
);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_PLOT  = 6'b000100,
        S_READ  = 6'b001000,
        S_DIV   = 6'b010000,
        S_CLR   = 6'b100000
    } state_t;

    state_t                             state_reg, state_next;
    logic [ADDR_BITS-1:0]               clr_cnt_reg, clr_cnt_next;
    logic                               clr_last;
    dtcf_pkg::ctl_t                     ctl_reg;
    logic [ADDR_BITS-1:0]               addr_reg;
    logic [DEPTH_BITS-1:0]              depth_reg;
    logic [DEPTH_BITS-1:0]              tie_reg;
    logic [15:0]                        data_reg;
    logic [dtcf_pkg::INDEX1_BITS-1:0]   index1_reg;

    logic                               done_reg, done_next;
    logic                               written_reg, written_next;
    logic                               in_range_reg, in_range_next;
    logic [7:0]                         cell_glyph_reg, cell_glyph_next;
    logic [7:0]                         cell_colour_reg, cell_colour_next;
    logic                               row_end_reg, row_end_next;

    logic [15:0]                        glyph_mem [CELLS];
    logic [DEPTH_BITS-1:0]              depth_mem [CELLS];
    logic [15:0]                        glyph_rd_reg;
    logic [DEPTH_BITS-1:0]              depth_rd_reg;
    logic                               glyph_we;
    logic                               depth_we;
    logic [ADDR_BITS-1:0]               wr_addr;
    logic [15:0]                        glyph_wdata;
    logic [DEPTH_BITS-1:0]              depth_wdata;
    logic                               take;
    logic                               rem_start;
    dtcf_pkg::rem_stat_t                rem_stat;

    dtcf_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (index1_reg),
        .divisor  (eff_w),
        .stat     (rem_stat)
    );

    assign clr_last = (clr_cnt_reg == ADDR_BITS'(CELLS - 1));

    // strictly nearer wins; on equal depth the tie-break depth must be nearer
    assign take = ctl_reg.in_range
               && ((depth_reg > depth_rd_reg)
                   || ((depth_reg == depth_rd_reg) && (tie_reg > depth_rd_reg)));

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        done_next        = 1'b0;
        written_next     = written_reg;
        in_range_next    = in_range_reg;
        cell_glyph_next  = cell_glyph_reg;
        cell_colour_next = cell_colour_reg;
        row_end_next     = row_end_reg;
        pop              = 1'b0;
        glyph_we         = 1'b0;
        depth_we         = 1'b0;
        wr_addr          = addr_reg;
        glyph_wdata      = data_reg;
        depth_wdata      = depth_reg;
        rem_start        = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                glyph_we    = 1'b1;
                depth_we    = 1'b1;
                wr_addr     = clr_cnt_reg;
                glyph_wdata = {8'h00, dtcf_pkg::SPACE_GLYPH};
                depth_wdata = '0;
                if (clr_last)
                begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    unique case (q_ctl.op)
                        dtcf_pkg::OP_PLOT:      state_next = S_PLOT;
                        dtcf_pkg::OP_READ:      state_next = S_READ;
                        dtcf_pkg::OP_CLR_GLYPH: state_next = S_CLR;
                        dtcf_pkg::OP_CLR_DEPTH: state_next = S_CLR;
                    endcase
                end
            end
            S_PLOT:
            begin
                glyph_we         = take;
                depth_we         = take;
                done_next        = 1'b1;
                written_next     = take;
                in_range_next    = ctl_reg.in_range;
                cell_glyph_next  = '0;
                cell_colour_next = '0;
                row_end_next     = 1'b0;
                state_next       = S_IDLE;
            end
            S_READ:
            begin
                written_next = 1'b0;
                if (ctl_reg.in_range)
                begin
                    rem_start        = 1'b1;
                    cell_glyph_next  = glyph_rd_reg[7:0];
                    cell_colour_next = glyph_rd_reg[15:8];
                    state_next       = S_DIV;
                end
                else
                begin
                    done_next        = 1'b1;
                    in_range_next    = 1'b0;
                    cell_glyph_next  = '0;
                    cell_colour_next = '0;
                    row_end_next     = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (rem_stat.done)
                begin
                    done_next     = 1'b1;
                    written_next  = 1'b0;
                    in_range_next = 1'b1;
                    row_end_next  = rem_stat.rem_zero;
                    state_next    = S_IDLE;
                end
            end
            S_CLR:
            begin
                glyph_we    = (ctl_reg.op == dtcf_pkg::OP_CLR_GLYPH);
                depth_we    = (ctl_reg.op == dtcf_pkg::OP_CLR_DEPTH);
                wr_addr     = clr_cnt_reg;
                glyph_wdata = {8'h00, dtcf_pkg::SPACE_GLYPH};
                depth_wdata = '0;
                if (clr_last)
                begin
                    clr_cnt_next     = '0;
                    done_next        = 1'b1;
                    written_next     = 1'b0;
                    in_range_next    = 1'b0;
                    cell_glyph_next  = '0;
                    cell_colour_next = '0;
                    row_end_next     = 1'b0;
                    state_next       = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
            ctl_reg     <= '{op: dtcf_pkg::OP_PLOT, in_range: 1'b0};
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
            if (pop)
            begin
                ctl_reg <= q_ctl;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            addr_reg   <= q_addr;
            depth_reg  <= q_depth;
            tie_reg    <= q_tie;
            data_reg   <= q_data;
            index1_reg <= q_index1;
        end
        written_reg     <= written_next;
        in_range_reg    <= in_range_next;
        cell_glyph_reg  <= cell_glyph_next;
        cell_colour_reg <= cell_colour_next;
        row_end_reg     <= row_end_next;
    end

    // stores: one write port, one registered read port at the queue head
    always_ff @(posedge clk)
    begin
        if (glyph_we)
        begin
            glyph_mem[wr_addr] <= glyph_wdata;
        end
        glyph_rd_reg <= glyph_mem[q_addr];
    end

    always_ff @(posedge clk)
    begin
        if (depth_we)
        begin
            depth_mem[wr_addr] <= depth_wdata;
        end
        depth_rd_reg <= depth_mem[q_addr];
    end

    assign init_busy   = (state_reg == S_INIT);
    assign done        = done_reg;
    assign written     = written_reg;
    assign in_range    = in_range_reg;
    assign cell_glyph  = cell_glyph_reg;
    assign cell_colour = cell_colour_reg;
    assign row_end     = row_end_reg;

    a_written_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && written_reg |-> in_range_reg)
        else $error("store reported for an out-of-range position");

    a_row_end_read: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && row_end_reg |-> in_range_reg && !written_reg)
        else $error("row end flagged outside an in-range read");

    a_plot_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PLOT |=> done_reg && state_reg == S_IDLE)
        else $error("plot did not finish in its write cycle");

    a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INIT |=> !done_reg)
        else $error("transaction completed during reset sweep");

endmodule

### src/depth_tested_char_framebuffer.sv
// character frame store with per-cell depth test; commands leave the 2-entry command queue,
// an in-range read runs one remainder bit per cycle and a clear sweeps every cell of one
// store; one accepted command at a time in the store
// start is taken while the queue has room and the reset sweep is over, so commands can
// queue while the store works; after reset busy stays high while both stores are swept
// every transaction gives one done strobe; the receiver cannot stall

module depth_tested_char_framebuffer #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64,
    parameter int DEPTH_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dtcf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dtcf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           cmd,
    input  logic signed [8:0]                    pos_x,
    input  logic signed [8:0]                    pos_y,
    input  logic [15:0]                          depth,
    input  logic [15:0]                          tie_depth,
    input  logic [7:0]                           glyph,
    input  logic [7:0]                           colour_index,
    input  logic [dtcf_pkg::CELL_INDEX_BITS-1:0] cell_index,
    output logic                                 done,
    output logic                                 written,
    output logic                                 in_range,
    output logic [7:0]                           cell_glyph,
    output logic [7:0]                           cell_colour,
    output logic                                 row_end
);

    localparam int CELLS     = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_BITS = $clog2(CELLS);
    localparam int CTL_BITS  = $bits(dtcf_pkg::ctl_t);
    localparam int Q_BITS    = CTL_BITS + ADDR_BITS + 2 * DEPTH_BITS + 16
                             + dtcf_pkg::INDEX1_BITS;

    dtcf_pkg::ctl_t                     fr_ctl;
    logic [ADDR_BITS-1:0]               fr_addr;
    logic [DEPTH_BITS-1:0]              fr_depth;
    logic [DEPTH_BITS-1:0]              fr_tie;
    logic [15:0]                        fr_data;
    logic [dtcf_pkg::INDEX1_BITS-1:0]   fr_index1;
    logic [dtcf_pkg::WIDTH_BITS-1:0]    eff_w;

    dtcf_pkg::ctl_t                     bk_ctl;
    logic [ADDR_BITS-1:0]               bk_addr;
    logic [DEPTH_BITS-1:0]              bk_depth;
    logic [DEPTH_BITS-1:0]              bk_tie;
    logic [15:0]                        bk_data;
    logic [dtcf_pkg::INDEX1_BITS-1:0]   bk_index1;

    logic [Q_BITS-1:0]                  q_in;
    logic [Q_BITS-1:0]                  q_head;
    logic                               q_push;
    logic                               q_pop;
    logic                               q_empty;
    logic                               q_full;
    logic                               init_busy;

    assign busy   = q_full || init_busy;
    assign q_push = start && !busy;

    dtcf_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .ADDR_BITS   (ADDR_BITS),
        .DEPTH_BITS  (DEPTH_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .depth        (depth),
        .tie_depth    (tie_depth),
        .glyph        (glyph),
        .colour_index (colour_index),
        .cell_index   (cell_index),
        .ctl          (fr_ctl),
        .addr         (fr_addr),
        .depth_val    (fr_depth),
        .tie_val      (fr_tie),
        .cell_data    (fr_data),
        .index1       (fr_index1),
        .eff_w        (eff_w)
    );

    assign q_in = {fr_ctl, fr_addr, fr_depth, fr_tie, fr_data, fr_index1};

    dtcf_queue #(
        .W (Q_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign {bk_ctl, bk_addr, bk_depth, bk_tie, bk_data, bk_index1} = q_head;

    dtcf_back #(
        .CELLS      (CELLS),
        .ADDR_BITS  (ADDR_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_ctl       (bk_ctl),
        .q_addr      (bk_addr),
        .q_depth     (bk_depth),
        .q_tie       (bk_tie),
        .q_data      (bk_data),
        .q_index1    (bk_index1),
        .eff_w       (eff_w),
        .pop         (q_pop),
        .init_busy   (init_busy),
        .done        (done),
        .written     (written),
        .in_range    (in_range),
        .cell_glyph  (cell_glyph),
        .cell_colour (cell_colour),
        .row_end     (row_end)
    );

endmodule
